>>> hw/rtl/lmpt_pkg.sv
// Shared types and constants of the longest-match phoneme tokenizer.
`timescale 1ns / 1ps

package lmpt_pkg;

  localparam int unsigned CODE_W      = 8;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] LEN_EMPTY  = 2'd0;
  localparam logic [1:0] LEN_SINGLE = 2'd1;
  localparam logic [1:0] LEN_PAIR   = 2'd2;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEXT = 1'b1
  } lmpt_op_e;

  typedef enum logic {
    KIND_PHONEME = 1'b0,
    KIND_END     = 1'b1
  } lmpt_kind_e;

  typedef struct packed {
    logic              found;
    logic [CODE_W-1:0] code;
  } lmpt_lookup_t;

  typedef struct packed {
    lmpt_lookup_t pair;
    lmpt_lookup_t held;
    lmpt_lookup_t fresh;
    logic         last;
  } lmpt_entry_t;

endpackage

>>> hw/rtl/lmpt_front.sv
// Front end: token table, parallel slot compare and two-level highest-slot select.
`timescale 1ns / 1ps

module lmpt_front import lmpt_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lmpt_op_e          op_i,
  input  logic [5:0]        entry_index_i,
  input  logic [1:0]        entry_length_i,
  input  logic [7:0]        entry_first_byte_i,
  input  logic [7:0]        entry_second_byte_i,
  input  logic [3:0]        entry_manner_i,
  input  logic [3:0]        entry_place_i,
  input  logic [7:0]        text_byte_i,
  input  logic              last_of_string_i,
  input  logic [QCNT_W-1:0] q_count_i,
  output logic              push_o,
  output lmpt_entry_t       push_entry_o
);

  localparam int unsigned GS  = 16;
  localparam int unsigned NG  = (TABLE_SLOTS + GS - 1) / GS;
  localparam int unsigned PAD = NG * GS;
  localparam int unsigned LK_PAIR = 0;
  localparam int unsigned LK_HELD = 1;
  localparam int unsigned LK_NEW  = 2;

  logic [1:0]        slot_len_q    [TABLE_SLOTS];
  logic [7:0]        slot_first_q  [TABLE_SLOTS];
  logic [7:0]        slot_second_q [TABLE_SLOTS];
  logic [CODE_W-1:0] slot_code_q   [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] slot_we;

  logic       accept, load_we, text_acc;
  logic [1:0] wr_len;
  logic [7:0] wr_second;
  logic [7:0] prev_q;

  logic [2:0][PAD-1:0] hit;
  logic [CODE_W-1:0]   code_pad [PAD];
  logic [2:0][NG-1:0]  grp_found;
  logic [CODE_W-1:0]   grp_code [3][NG];

  logic               a_valid_q, a_last_q;
  logic [2:0][NG-1:0] a_found_q;
  logic [CODE_W-1:0]  a_code_q [3][NG];
  lmpt_lookup_t       res [3];

  assign in_ready_o = (4'(q_count_i) + 4'(a_valid_q)) < 4'(QUEUE_DEPTH);
  assign accept     = in_valid_i && in_ready_o;
  assign load_we    = accept && (op_i == OP_LOAD);
  assign text_acc   = accept && (op_i == OP_TEXT);
  assign wr_len     = (entry_length_i > LEN_PAIR) ? LEN_EMPTY : entry_length_i;
  assign wr_second  = (wr_len == LEN_PAIR) ? entry_second_byte_i : 8'd0;

  for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_slot
    assign slot_we[i] = load_we && (9'(entry_index_i) == 9'(i));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        slot_len_q[i] <= LEN_EMPTY;
      end else if (slot_we[i]) begin
        slot_len_q[i] <= wr_len;
      end
    end

    always_ff @(posedge clk_i) begin
      if (slot_we[i]) begin
        slot_first_q[i]  <= entry_first_byte_i;
        slot_second_q[i] <= wr_second;
        slot_code_q[i]   <= {entry_manner_i, entry_place_i};
      end
    end
  end

  always_comb begin
    hit = '0;
    for (int i = 0; i < PAD; i++) begin
      code_pad[i] = '0;
      if (i < TABLE_SLOTS) begin
        code_pad[i] = slot_code_q[i];
        hit[LK_PAIR][i] = (slot_len_q[i] == LEN_PAIR) && (slot_first_q[i] == prev_q) &&
                          (slot_second_q[i] == text_byte_i);
        hit[LK_HELD][i] = (slot_len_q[i] == LEN_SINGLE) && (slot_first_q[i] == prev_q);
        hit[LK_NEW][i]  = (slot_len_q[i] == LEN_SINGLE) &&
                          (slot_first_q[i] == text_byte_i);
      end
    end
  end

  always_comb begin
    logic [GS-1:0] gv;
    logic          sel;
    for (int k = 0; k < 3; k++) begin
      for (int g = 0; g < NG; g++) begin
        gv = hit[k][g*GS +: GS];
        grp_found[k][g] = |gv;
        grp_code[k][g]  = '0;
        for (int j = 0; j < GS; j++) begin
          sel = gv[j] && !(|(gv >> (j + 1)));
          grp_code[k][g] = grp_code[k][g] | ({CODE_W{sel}} & code_pad[g*GS + j]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      prev_q    <= 8'd0;
    end else begin
      a_valid_q <= text_acc;
      if (text_acc) begin
        prev_q <= text_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_acc) begin
      a_last_q  <= last_of_string_i;
      a_found_q <= grp_found;
      a_code_q  <= grp_code;
    end
  end

  always_comb begin
    logic [NG-1:0] fv;
    logic          sel;
    for (int k = 0; k < 3; k++) begin
      fv = a_found_q[k];
      res[k].found = |fv;
      res[k].code  = '0;
      for (int g = 0; g < NG; g++) begin
        sel = fv[g] && !(|(fv >> (g + 1)));
        res[k].code = res[k].code | ({CODE_W{sel}} & a_code_q[k][g]);
      end
    end
  end

  assign push_o             = a_valid_q;
  assign push_entry_o.pair  = res[LK_PAIR];
  assign push_entry_o.held  = res[LK_HELD];
  assign push_entry_o.fresh = res[LK_NEW];
  assign push_entry_o.last  = a_last_q;

endmodule

>>> hw/rtl/lmpt_queue.sv
// Short request queue between the classifying front end and the emitting back end.
`timescale 1ns / 1ps

module lmpt_queue import lmpt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lmpt_entry_t       push_entry_i,
  input  logic              pop_i,
  output logic              valid_o,
  output lmpt_entry_t       head_o,
  output logic [QCNT_W-1:0] count_o
);

  lmpt_entry_t       mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < QCNT_W'(QUEUE_DEPTH)))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue pop while empty");

endmodule

>>> hw/rtl/lmpt_back.sv
// Back end: resolve the held byte, then emit up to three results per text byte.
`timescale 1ns / 1ps

module lmpt_back import lmpt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  lmpt_entry_t q_entry_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output lmpt_kind_e  out_kind_o,
  output logic [CODE_W-1:0] out_code_o,
  output logic        out_last_o
);

  localparam int unsigned RES_FIRST = 0;
  localparam int unsigned RES_FLUSH = 1;
  localparam int unsigned RES_END   = 2;

  logic              hv_q, hv_d;
  logic [2:0]        mask_q, mask_d, mask_new, mask_next;
  logic [CODE_W-1:0] code0_q, code1_q, first_code;
  logic              busy, out_free, emit, finishing, pair_hit, hv_mid;

  logic              out_valid_q, out_last_q;
  lmpt_kind_e        out_kind_q, emit_kind;
  logic [CODE_W-1:0] out_code_q, emit_code;

  assign busy      = |mask_q;
  assign out_free  = !out_valid_q || out_ready_i;
  assign emit      = busy && out_free;
  assign finishing = emit && (mask_next == 3'b000);
  assign q_pop_o   = q_valid_i && (!busy || finishing);

  always_comb begin
    pair_hit   = hv_q && q_entry_i.pair.found;
    hv_mid     = !pair_hit;
    first_code = pair_hit ? q_entry_i.pair.code : q_entry_i.held.code;
    mask_new   = 3'b000;
    mask_new[RES_FIRST] = pair_hit || (hv_q && q_entry_i.held.found);
    mask_new[RES_FLUSH] = q_entry_i.last && hv_mid && q_entry_i.fresh.found;
    mask_new[RES_END]   = q_entry_i.last;
    hv_d = q_entry_i.last ? 1'b0 : hv_mid;
  end

  always_comb begin
    emit_kind = KIND_PHONEME;
    emit_code = code0_q;
    mask_next = 3'b000;
    if (mask_q[RES_FIRST]) begin
      mask_next = mask_q & 3'b110;
    end else if (mask_q[RES_FLUSH]) begin
      emit_code = code1_q;
      mask_next = mask_q & 3'b100;
    end else begin
      emit_kind = KIND_END;
      emit_code = '0;
    end
  end

  always_comb begin
    mask_d = mask_q;
    if (q_pop_o) begin
      mask_d = mask_new;
    end else if (emit) begin
      mask_d = mask_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q        <= 1'b0;
      mask_q      <= 3'b000;
      out_valid_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (q_pop_o) begin
        hv_q <= hv_d;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      code0_q <= first_code;
      code1_q <= q_entry_i.fresh.code;
    end
    if (emit) begin
      out_kind_q <= emit_kind;
      out_code_q <= emit_code;
      out_last_q <= (mask_next == 3'b000);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_code_o  = out_code_q;
  assign out_last_o  = out_last_q;

  a_end_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q == KIND_END)) |-> (out_last_q && (out_code_q == '0)))
    else $error("end marker without last flag or with nonzero codes");

  a_last_clears_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && q_entry_i.last) |=> (!hv_q && mask_q[RES_END]))
    else $error("string end did not clear held byte or queue end marker");

  a_stall_holds_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && !out_free) |=> $stable(mask_q))
    else $error("pending results changed while output stalled");

endmodule

>>> hw/rtl/longest_match_phoneme_tokenizer.sv
// Top level of the greedy longest-match phoneme tokenizer.
`timescale 1ns / 1ps

// Requests enter on s_axis: tuser selects a table load (0) or a text byte (1),
// tlast marks the last byte of a string. Loads write one table slot and give no
// result. Each text byte gives zero to three results on m_axis: tuser is the kind
// (0 phoneme, 1 end of string marker), tlast marks the final result of the byte.
// Throughput: one request per cycle while each byte gives at most one result and
// the receiver is ready; a byte with two or three results holds up the bytes behind
// it, since the back end emits one result per cycle through its output register.
// After its byte is accepted, a single result passes through slot compare and group
// select, final select into the queue, result decode in the back end and the emit
// register before it appears on m_axis.
// Reset empties every table slot and drops the held byte; no sweep is needed.
// When the receiver stalls, the four-entry queue fills and s_axis_tready drops.
module longest_match_phoneme_tokenizer import lmpt_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // entry_index[5:0], entry_length[7:6], entry_first_byte[15:8],
  // entry_second_byte[23:16], entry_manner[27:24], entry_place[31:28], text_byte[39:32]
  input  logic [39:0] s_axis_tdata_i,
  // operation[0]
  input  logic        s_axis_tuser_i,
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // manner[3:0], place[7:4]
  output logic [7:0]  m_axis_tdata_o,
  // kind[0]
  output logic        m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  logic              push, pop, q_valid;
  lmpt_entry_t       push_entry, head;
  logic [QCNT_W-1:0] q_count;
  lmpt_kind_e        out_kind;
  logic [CODE_W-1:0] out_code;

  lmpt_front #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (s_axis_tvalid_i),
    .in_ready_o         (s_axis_tready_o),
    .op_i               (lmpt_op_e'(s_axis_tuser_i)),
    .entry_index_i      (s_axis_tdata_i[5:0]),
    .entry_length_i     (s_axis_tdata_i[7:6]),
    .entry_first_byte_i (s_axis_tdata_i[15:8]),
    .entry_second_byte_i(s_axis_tdata_i[23:16]),
    .entry_manner_i     (s_axis_tdata_i[27:24]),
    .entry_place_i      (s_axis_tdata_i[31:28]),
    .text_byte_i        (s_axis_tdata_i[39:32]),
    .last_of_string_i   (s_axis_tlast_i),
    .q_count_i          (q_count),
    .push_o             (push),
    .push_entry_o       (push_entry)
  );

  lmpt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head),
    .count_o     (q_count)
  );

  lmpt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_entry_i  (head),
    .q_pop_o    (pop),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_kind_o (out_kind),
    .out_code_o (out_code),
    .out_last_o (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {out_code[3:0], out_code[7:4]};
  assign m_axis_tuser_o = out_kind;

endmodule
